[sv/chtm_pkg.sv]
package chtm_pkg;

    // default geometry
    localparam int MAX_LINES_DEF   = 64;
    localparam int OFFSET_BITS_DEF = 6;
    localparam int ADDR_BITS_DEF   = 32;

    // fixed port widths
    localparam int ADDR_W     = 32;
    localparam int COUNT_W    = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_LOG2   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FULLY_ASSOC = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPLIT_MODE  = 2'd2;

    localparam logic [CFG_DATA_W-1:0] SIZE_LOG2_RST = 4'd12;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic rd_dm;
        logic fill_dm;
        logic scan_rd;
        logic fill_scan;
        logic fill_victim;
        logic set_hit;
        logic hit_val;
        logic commit;
    } chtm_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic fully_assoc;
        logic dm_valid;
        logic match;
        logic scan_valid;
        logic scan_end;
        logic out_free;
    } chtm_stat_t;

endpackage

[sv/chtm_if.sv]
interface chtm_req_if
    import chtm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] address;
    logic              is_data;

    modport source (output valid, output address, output is_data, input ready);
    modport sink   (input valid, input address, input is_data, output ready);
endinterface

interface chtm_rsp_if
    import chtm_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               hit;
    logic [COUNT_W-1:0] access_count;
    logic [COUNT_W-1:0] hit_count;

    modport source (output valid, output hit, output access_count, output hit_count,
                    input ready);
    modport sink   (input valid, input hit, input access_count, input hit_count,
                    output ready);
endinterface

[sv/chtm_controller.sv]
module chtm_controller
    import chtm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  chtm_stat_t stat,
    output chtm_cmd_t  cmd
);

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_DISPATCH = 6'b000010,
        ST_DM_CMP   = 6'b000100,
        ST_SCAN0    = 6'b001000,
        ST_SCANP    = 6'b010000,
        ST_RESULT   = 6'b100000
    } chtm_state_t;

    chtm_state_t state_reg;
    chtm_state_t state_next;

    assign req_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (stat.fully_assoc)
                begin
                    state_next = ST_SCAN0;
                end
                else if (stat.dm_valid)
                begin
                    cmd.rd_dm  = 1'b1;
                    state_next = ST_DM_CMP;
                end
                else
                begin
                    cmd.fill_dm = 1'b1;
                    cmd.set_hit = 1'b1;
                    state_next  = ST_RESULT;
                end
            end
            ST_DM_CMP:
            begin
                cmd.set_hit = 1'b1;
                cmd.hit_val = stat.match;
                cmd.fill_dm = !stat.match;
                state_next  = ST_RESULT;
            end
            ST_SCAN0, ST_SCANP:
            begin
                // in scanp the tag of the previous line is in the read register
                if ((state_reg == ST_SCANP) && stat.match)
                begin
                    cmd.set_hit = 1'b1;
                    cmd.hit_val = 1'b1;
                    state_next  = ST_RESULT;
                end
                else if (stat.scan_end)
                begin
                    cmd.fill_victim = 1'b1;
                    cmd.set_hit     = 1'b1;
                    state_next      = ST_RESULT;
                end
                else if (!stat.scan_valid)
                begin
                    cmd.fill_scan = 1'b1;
                    cmd.set_hit   = 1'b1;
                    state_next    = ST_RESULT;
                end
                else
                begin
                    cmd.scan_rd = 1'b1;
                    state_next  = ST_SCANP;
                end
            end
            ST_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[sv/chtm_datapath.sv]
module chtm_datapath
    import chtm_pkg::*;
#(
    parameter int MAX_LINES   = MAX_LINES_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int ADDR_BITS   = ADDR_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [ADDR_W-1:0]     address,
    input  logic                  is_data,
    input  chtm_cmd_t             cmd,
    output chtm_stat_t            stat,
    input  logic                  rsp_ready,
    output logic                  rsp_valid,
    output logic                  hit,
    output logic [COUNT_W-1:0]    access_count,
    output logic [COUNT_W-1:0]    hit_count
);

    localparam int INSTR_LINES  = (MAX_LINES / 2 < 1) ? 1 : MAX_LINES / 2;
    localparam int TAG_W        = ADDR_BITS - OFFSET_BITS;
    localparam int LINE_EXP_MAX = $clog2(MAX_LINES + 1) - 1;
    localparam int EXP_W        = $clog2(LINE_EXP_MAX + 1);
    localparam int CNT_W        = LINE_EXP_MAX + 1;
    localparam int IDX_W        = $clog2(MAX_LINES);
    localparam int IIDX_W       = (INSTR_LINES > 1) ? $clog2(INSTR_LINES) : 1;

    // configuration
    logic [CFG_DATA_W-1:0] size_log2_reg;
    logic                  fully_assoc_reg;
    logic                  split_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_log2_reg   <= SIZE_LOG2_RST;
            fully_assoc_reg <= 1'b0;
            split_reg       <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SIZE_LOG2:   size_log2_reg   <= cfg_data;
                REG_FULLY_ASSOC: fully_assoc_reg <= cfg_data[0];
                REG_SPLIT_MODE:  split_reg       <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // line exponent of the store in use, clamped to the store size
    logic signed [5:0] exp_raw;
    logic signed [5:0] exp_cap;
    logic [EXP_W-1:0]  line_exp;
    logic [CNT_W-1:0]  lines;
    logic [CNT_W-1:0]  line_mask;

    assign exp_raw = $signed({2'b00, size_log2_reg}) - $signed(6'(OFFSET_BITS))
                   - $signed({5'b00000, split_reg});
    assign exp_cap = split_reg ? $signed(6'(LINE_EXP_MAX - 1)) : $signed(6'(LINE_EXP_MAX));

    always_comb
    begin
        if (exp_raw < 0)
        begin
            line_exp = '0;
        end
        else if (exp_raw > exp_cap)
        begin
            line_exp = EXP_W'(exp_cap);
        end
        else
        begin
            line_exp = EXP_W'(exp_raw);
        end
    end

    assign lines     = CNT_W'(1) << line_exp;
    assign line_mask = lines - CNT_W'(1);

    // request decode
    logic [ADDR_BITS-1:0] addr_m;
    logic [TAG_W-1:0]     fa_tag;
    logic [TAG_W-1:0]     tag_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic                 use_instr_reg;
    logic                 is_data_reg;
    logic [CNT_W-1:0]     cnt_reg;

    assign addr_m = address[ADDR_BITS-1:0];
    assign fa_tag = addr_m[ADDR_BITS-1:OFFSET_BITS];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            tag_reg       <= fully_assoc_reg ? fa_tag : (fa_tag >> line_exp);
            idx_reg       <= fa_tag[IDX_W-1:0] & line_mask[IDX_W-1:0];
            use_instr_reg <= split_reg && !is_data;
            is_data_reg   <= is_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.load)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.scan_rd)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    // fifo victim pointers
    logic [IDX_W-1:0] uni_ptr_reg;
    logic [IDX_W-1:0] data_ptr_reg;
    logic [IDX_W-1:0] instr_ptr_reg;
    logic [IDX_W-1:0] ptr_sel;
    logic [IDX_W-1:0] victim;
    logic [IDX_W-1:0] ptr_next;

    assign ptr_sel  = !split_reg ? uni_ptr_reg : (is_data_reg ? data_ptr_reg : instr_ptr_reg);
    assign victim   = ptr_sel & line_mask[IDX_W-1:0];
    assign ptr_next = (victim + IDX_W'(1)) & line_mask[IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            uni_ptr_reg   <= '0;
            data_ptr_reg  <= '0;
            instr_ptr_reg <= '0;
        end
        else if (cmd.fill_victim)
        begin
            if (!split_reg)
            begin
                uni_ptr_reg <= ptr_next;
            end
            else if (is_data_reg)
            begin
                data_ptr_reg <= ptr_next;
            end
            else
            begin
                instr_ptr_reg <= ptr_next;
            end
        end
    end

    // tag stores
    logic [TAG_W-1:0]       main_tag_mem  [MAX_LINES];
    logic [TAG_W-1:0]       instr_tag_mem [INSTR_LINES];
    logic [TAG_W-1:0]       main_rd_reg;
    logic [TAG_W-1:0]       instr_rd_reg;
    logic [MAX_LINES-1:0]   main_valid_reg;
    logic [INSTR_LINES-1:0] instr_valid_reg;
    logic [IDX_W-1:0]       rd_idx;
    logic [IDX_W-1:0]       wr_idx;
    logic                   rd_en;
    logic                   wr_en;
    logic [TAG_W-1:0]       rd_data;

    assign rd_en  = cmd.rd_dm || cmd.scan_rd;
    assign wr_en  = cmd.fill_dm || cmd.fill_scan || cmd.fill_victim;
    assign rd_idx = cmd.rd_dm ? idx_reg : cnt_reg[IDX_W-1:0];
    assign wr_idx = cmd.fill_dm ? idx_reg : (cmd.fill_scan ? cnt_reg[IDX_W-1:0] : victim);

    always_ff @(posedge clk)
    begin
        if (wr_en && !use_instr_reg)
        begin
            main_tag_mem[wr_idx] <= tag_reg;
        end
        if (rd_en)
        begin
            main_rd_reg <= main_tag_mem[rd_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && use_instr_reg)
        begin
            instr_tag_mem[wr_idx[IIDX_W-1:0]] <= tag_reg;
        end
        if (rd_en)
        begin
            instr_rd_reg <= instr_tag_mem[rd_idx[IIDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg  <= '0;
            instr_valid_reg <= '0;
        end
        else if (wr_en)
        begin
            if (use_instr_reg)
            begin
                instr_valid_reg[wr_idx[IIDX_W-1:0]] <= 1'b1;
            end
            else
            begin
                main_valid_reg[wr_idx] <= 1'b1;
            end
        end
    end

    assign rd_data = use_instr_reg ? instr_rd_reg : main_rd_reg;

    // result and counters
    logic               hit_reg;
    logic               hit_out_reg;
    logic               out_valid_reg;
    logic [COUNT_W-1:0] acc_reg;
    logic [COUNT_W-1:0] hits_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.set_hit)
        begin
            hit_reg <= cmd.hit_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            hit_out_reg   <= 1'b0;
            acc_reg       <= '0;
            hits_reg      <= '0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
            hit_out_reg   <= hit_reg;
            acc_reg       <= acc_reg + COUNT_W'(1);
            hits_reg      <= hits_reg + COUNT_W'(hit_reg);
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // counters only move at commit, so they double as the output register
    assign rsp_valid    = out_valid_reg;
    assign hit          = hit_out_reg;
    assign access_count = acc_reg;
    assign hit_count    = hits_reg;

    always_comb
    begin
        stat.fully_assoc = fully_assoc_reg;
        stat.dm_valid    = use_instr_reg ? instr_valid_reg[idx_reg[IIDX_W-1:0]]
                                         : main_valid_reg[idx_reg];
        stat.match       = (rd_data == tag_reg);
        stat.scan_valid  = use_instr_reg ? instr_valid_reg[cnt_reg[IIDX_W-1:0]]
                                         : main_valid_reg[cnt_reg[IDX_W-1:0]];
        stat.scan_end    = (cnt_reg == lines);
        stat.out_free    = !out_valid_reg || rsp_ready;
    end

endmodule

[sv/cache_tag_hit_miss_model_core.sv]
// Tag-side cache model with 2^OFFSET_BITS-byte lines, direct mapped or fully
// associative with FIFO replacement, unified or split into instruction and data
// halves. One request is handled at a time and gives one result with the hit
// flag and the running access and hit counts. A direct-mapped request reads and
// compares the indexed tag, or fills an invalid line, before its result; a fully
// associative request is settled by a sequential search that reads one stored
// tag per cycle through the single read port of the tag memory. A new request
// is accepted as soon as the previous result is in the output register, even
// while it waits to be taken. Valid bits are cleared at reset at once; there is
// no clearing pass. Configuration may only be written while no request is in
// flight; stored tags and pointers survive reconfiguration.
module cache_tag_hit_miss_model_core
    import chtm_pkg::*;
#(
    parameter int MAX_LINES   = MAX_LINES_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int ADDR_BITS   = ADDR_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    chtm_req_if.sink              req,
    chtm_rsp_if.source            rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    chtm_cmd_t  cmd;
    chtm_stat_t stat;

    chtm_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    chtm_datapath #(
        .MAX_LINES   (MAX_LINES),
        .OFFSET_BITS (OFFSET_BITS),
        .ADDR_BITS   (ADDR_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .address      (req.address),
        .is_data      (req.is_data),
        .cmd          (cmd),
        .stat         (stat),
        .rsp_ready    (rsp.ready),
        .rsp_valid    (rsp.valid),
        .hit          (rsp.hit),
        .access_count (rsp.access_count),
        .hit_count    (rsp.hit_count)
    );

    // a result is only committed into a free output register
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> stat.out_free)
        else $error("result committed over a pending result");

    // at most one tag write per cycle
    a_one_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.fill_dm, cmd.fill_scan, cmd.fill_victim}))
        else $error("conflicting tag writes");

    // a committed result shows up on the next cycle
    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> rsp.valid)
        else $error("committed result not presented");

    // one request at a time
    a_single_req: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("second request accepted while busy");

endmodule
